// ===== src/wts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and register codes for the world-to-screen projection block.
// No dependencies; every other file imports this package.
package wts_pkg;

	localparam int COEF_W     = 16;  // signed matrix coefficient
	localparam int POS_W      = 16;  // signed world coordinate
	localparam int POS_FRAC   = 8;   // fraction bits of a world coordinate
	localparam int OUT_W      = 24;  // signed window coordinate
	localparam int VIEW_W     = 34;  // view-space sum of four 32-bit products
	localparam int PROD_W     = 50;  // coefficient times view-space value
	localparam int CLIP_W     = 52;  // clip-space sum of four products
	localparam int NUM_W      = 53;  // clip sum or difference before division
	localparam int QUO_W      = 25;  // quotient bits kept, enough to detect overflow
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int XF_STAGES  = 4;   // register stages in the matrix unit

	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [POS_W-1:0]   pos_t;
	typedef logic signed [OUT_W-1:0]   scr_t;
	typedef logic signed [CLIP_W-1:0]  clip_t;
	typedef logic [3:0][CFG_DATA_W-1:0] mat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VIEW_COL0 = 3'd0,
		CFG_VIEW_COL1 = 3'd1,
		CFG_VIEW_COL2 = 3'd2,
		CFG_VIEW_COL3 = 3'd3,
		CFG_PROJ_COL0 = 3'd4,
		CFG_PROJ_COL1 = 3'd5,
		CFG_PROJ_COL2 = 3'd6,
		CFG_PROJ_COL3 = 3'd7
	} cfg_idx_t;

	localparam logic [CFG_DATA_W-1:0] COEF_ONE = 64'h1000;
	localparam scr_t OUT_MAX = 24'sh7FFFFF;
	localparam scr_t OUT_MIN = 24'sh800000;

	// Side bits that ride along with a division
	typedef struct packed {
		logic wz;
		logic neg;
	} div_tag_t;

	// Divider result: overflow, magnitude quotient and side bits
	typedef struct packed {
		logic            ovf;
		logic [QUO_W-1:0] quo;
		div_tag_t        tag;
	} div_res_t;

	function automatic mat_t ident_mat();
		mat_t m;
		for (int c = 0; c < 4; c++) begin
			m[c] = COEF_ONE << (COEF_W * c);
		end
		return m;
	endfunction

	function automatic coef_t coef_of(mat_t m, int col, int row);
		return coef_t'(m[col][COEF_W*row +: COEF_W]);
	endfunction

endpackage

// ===== src/wts_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the projection block: position in, window coordinates out,
// and the register write port. Depends on wts_pkg.
interface pos_if;
	import wts_pkg::*;
	logic valid;
	logic ready;
	pos_t pos_x;
	pos_t pos_y;
	pos_t pos_z;
	modport source(output valid, pos_x, pos_y, pos_z, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface scr_if;
	import wts_pkg::*;
	logic valid;
	logic ready;
	scr_t screen_x;
	scr_t screen_y;
	logic w_zero;
	logic saturated;
	modport source(output valid, screen_x, screen_y, w_zero, saturated, input ready);
	modport sink(input valid, screen_x, screen_y, w_zero, saturated, output ready);
endinterface

interface cfg_if;
	import wts_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/wts_xform.sv =====
`timescale 1ns / 1ps
// Four-stage matrix unit: view transform then projection, clip x, y and w only.
// Depends on wts_pkg.
module wts_xform (
	input  logic          clk,
	input  logic          en,
	input  wts_pkg::pos_t pos_x,
	input  wts_pkg::pos_t pos_y,
	input  wts_pkg::pos_t pos_z,
	input  wts_pkg::mat_t view,
	input  wts_pkg::mat_t proj,
	output wts_pkg::clip_t clip_x,
	output wts_pkg::clip_t clip_y,
	output wts_pkg::clip_t clip_w
);
	import wts_pkg::*;

	localparam int VP_W = 2 * COEF_W;

	pos_t                     pin [3];
	logic signed [VP_W-1:0]   vprod_s1 [4][4];
	logic signed [VIEW_W-1:0] view_s2 [4];
	logic signed [PROD_W-1:0] pprod_s3 [3][4];
	clip_t                    clip_s4 [3];

	assign pin[0] = pos_x;
	assign pin[1] = pos_y;
	assign pin[2] = pos_z;

	// Clip z is unused: row 2 of the projection is skipped
	function automatic int proj_row(int k);
		return (k == 2) ? 3 : k;
	endfunction

	// Stage 1: view products, translation scaled to the same fraction
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					vprod_s1[r][c] <= coef_of(view, c, r) * pin[c];
				end
				vprod_s1[r][3] <= VP_W'(coef_of(view, 3, r)) <<< POS_FRAC;
			end
		end
	end

	// Stage 2: view-space sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				view_s2[r] <= VIEW_W'(vprod_s1[r][0]) + VIEW_W'(vprod_s1[r][1])
					+ VIEW_W'(vprod_s1[r][2]) + VIEW_W'(vprod_s1[r][3]);
			end
		end
	end

	// Stage 3: projection products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int c = 0; c < 4; c++) begin
					pprod_s3[k][c] <= coef_of(proj, c, proj_row(k)) * view_s2[c];
				end
			end
		end
	end

	// Stage 4: clip-space sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				clip_s4[k] <= CLIP_W'(pprod_s3[k][0]) + CLIP_W'(pprod_s3[k][1])
					+ CLIP_W'(pprod_s3[k][2]) + CLIP_W'(pprod_s3[k][3]);
			end
		end
	end

	assign clip_x = clip_s4[0];
	assign clip_y = clip_s4[1];
	assign clip_w = clip_s4[2];

endmodule

// ===== src/wts_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: floor((n << SHIFT) / d), one quotient bit per stage,
// with an overflow check up front. Depends on wts_pkg.
module wts_div #(
	parameter int SHIFT = 15
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [wts_pkg::NUM_W-1:0]  n,
	input  logic [wts_pkg::CLIP_W-1:0] d,
	input  wts_pkg::div_tag_t       tag_in,
	output wts_pkg::div_res_t       res
);
	import wts_pkg::*;

	localparam int N_SH = NUM_W + SHIFT;
	localparam int WW   = (N_SH > CLIP_W + QUO_W) ? N_SH : CLIP_W + QUO_W;

	logic [WW-1:0]     rem_s [QUO_W+1];
	logic [CLIP_W-1:0] den_s [QUO_W+1];
	logic [QUO_W-1:0]  quo_s [QUO_W+1];
	logic              ovf_s [QUO_W+1];
	div_tag_t          tag_s [QUO_W+1];

	logic [WW-1:0] n_sh;
	logic [WW-1:0] dsh  [QUO_W+1];
	logic          take [QUO_W+1];

	assign n_sh = WW'(n) << SHIFT;

	// Trial subtract of the divisor at the weight of each quotient bit
	always_comb begin
		dsh[0]  = WW'(d) << QUO_W;
		take[0] = 1'b0;
		for (int j = 1; j <= QUO_W; j++) begin
			dsh[j]  = WW'(den_s[j-1]) << (QUO_W - j);
			take[j] = rem_s[j-1] >= dsh[j];
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= n_sh;
			den_s[0] <= d;
			quo_s[0] <= '0;
			ovf_s[0] <= n_sh >= dsh[0];
			tag_s[0] <= tag_in;
			for (int j = 1; j <= QUO_W; j++) begin
				rem_s[j] <= take[j] ? rem_s[j-1] - dsh[j] : rem_s[j-1];
				den_s[j] <= den_s[j-1];
				quo_s[j] <= {quo_s[j-1][QUO_W-2:0], take[j]};
				ovf_s[j] <= ovf_s[j-1];
				tag_s[j] <= tag_s[j-1];
			end
		end
	end

	assign res.ovf = ovf_s[QUO_W];
	assign res.quo = quo_s[QUO_W];
	assign res.tag = tag_s[QUO_W];

endmodule

// ===== src/world_to_screen_projection.sv =====
`timescale 1ns / 1ps
// Top level of the world-to-screen projection: registers, matrix unit, two dividers,
// clamp stage and output skid. Depends on wts_pkg, wts_if, wts_xform, wts_div.
//
//   channel  dir  modport       payload
//   pos      in   pos_if.sink   pos_x, pos_y, pos_z (signed Q8.8)
//   scr      out  scr_if.source screen_x, screen_y (signed Q8.16), w_zero, saturated
//   cfg      in   cfg_if.sink   index (0..7), data (64-bit matrix column)
//
// One request enters per cycle while the skid register is empty; the pipeline has 33 stages
// (four matrix, two numerator, 26 divider, one final) plus the output register for any
// OUT_FRAC_BITS, since the one-bit-per-stage dividers are sized by QUO_W.
// Reset restores identity matrices and empties the pipeline; cfg is always ready.
// A stalled output parks one result in the skid register, then the whole pipeline holds.
module world_to_screen_projection #(
	parameter int OUT_FRAC_BITS = 16  // 8..20
) (
	input  logic  clk,
	input  logic  arst_n,
	pos_if.sink   pos,
	scr_if.source scr,
	cfg_if.sink   cfg
);
	import wts_pkg::*;

	localparam int DIV_SHIFT = OUT_FRAC_BITS - 1;
	localparam int STAGES    = XF_STAGES + 2 + QUO_W + 1 + 1;
	localparam logic [QUO_W-1:0] LIM_POS = QUO_W'((2 ** (OUT_W - 1)) - 1);
	localparam logic [QUO_W-1:0] LIM_NEG = QUO_W'(2 ** (OUT_W - 1));

	typedef struct packed {
		scr_t x;
		scr_t y;
		logic wz;
		logic sat;
	} scr_pl_t;

	typedef struct packed {
		scr_t val;
		logic sat;
	} coord_t;

	mat_t view_q;
	mat_t proj_q;
	logic [STAGES-1:0] vld_q;
	logic en;
	logic out_vld_q;
	logic skid_vld_q;
	scr_pl_t out_q;
	scr_pl_t skid_q;
	scr_pl_t fin_s;
	scr_pl_t fin_d;
	logic load_out;
	logic load_skid;
	logic skid_to_out;

	clip_t clip_x;
	clip_t clip_y;
	clip_t clip_w;
	logic signed [NUM_W-1:0] numx_s5;
	logic signed [NUM_W-1:0] numy_s5;
	clip_t                   den_s5;
	logic [NUM_W-1:0]  nmagx_s6;
	logic [NUM_W-1:0]  nmagy_s6;
	logic [CLIP_W-1:0] dmag_s6;
	div_tag_t          tagx_s6;
	div_tag_t          tagy_s6;
	div_res_t          resx;
	div_res_t          resy;
	coord_t            cx;
	coord_t            cy;

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_q <= ident_mat();
			proj_q <= ident_mat();
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_VIEW_COL0: view_q[0] <= cfg.data;
				CFG_VIEW_COL1: view_q[1] <= cfg.data;
				CFG_VIEW_COL2: view_q[2] <= cfg.data;
				CFG_VIEW_COL3: view_q[3] <= cfg.data;
				CFG_PROJ_COL0: proj_q[0] <= cfg.data;
				CFG_PROJ_COL1: proj_q[1] <= cfg.data;
				CFG_PROJ_COL2: proj_q[2] <= cfg.data;
				CFG_PROJ_COL3: proj_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// Pipeline advances unless the skid holds a result
	assign en        = !skid_vld_q;
	assign pos.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], pos.valid};
		end
	end

	// Matrix stages
	wts_xform u_xform (
		.clk    (clk),
		.en     (en),
		.pos_x  (pos.pos_x),
		.pos_y  (pos.pos_y),
		.pos_z  (pos.pos_z),
		.view   (view_q),
		.proj   (proj_q),
		.clip_x (clip_x),
		.clip_y (clip_y),
		.clip_w (clip_w)
	);

	// Stage 5: numerators
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s5 <= NUM_W'(clip_x) + NUM_W'(clip_w);
			numy_s5 <= NUM_W'(clip_w) - NUM_W'(clip_y);
			den_s5  <= clip_w;
		end
	end

	// Stage 6: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			nmagx_s6    <= numx_s5[NUM_W-1] ? NUM_W'(-numx_s5) : NUM_W'(numx_s5);
			nmagy_s6    <= numy_s5[NUM_W-1] ? NUM_W'(-numy_s5) : NUM_W'(numy_s5);
			dmag_s6     <= den_s5[CLIP_W-1] ? CLIP_W'(-den_s5) : CLIP_W'(den_s5);
			tagx_s6.neg <= numx_s5[NUM_W-1] ^ den_s5[CLIP_W-1];
			tagx_s6.wz  <= den_s5 == '0;
			tagy_s6.neg <= numy_s5[NUM_W-1] ^ den_s5[CLIP_W-1];
			tagy_s6.wz  <= 1'b0;
		end
	end

	wts_div #(.SHIFT(DIV_SHIFT)) u_div_x (
		.clk    (clk),
		.en     (en),
		.n      (nmagx_s6),
		.d      (dmag_s6),
		.tag_in (tagx_s6),
		.res    (resx)
	);

	wts_div #(.SHIFT(DIV_SHIFT)) u_div_y (
		.clk    (clk),
		.en     (en),
		.n      (nmagy_s6),
		.d      (dmag_s6),
		.tag_in (tagy_s6),
		.res    (resy)
	);

	// Clamp the quotient magnitude and apply the sign
	function automatic coord_t clamp_coord(div_res_t r);
		logic [QUO_W-1:0] lim;
		logic [QUO_W-1:0] mag;
		logic             over;
		coord_t           c;
		lim   = r.tag.neg ? LIM_NEG : LIM_POS;
		over  = r.ovf || (r.quo > lim);
		mag   = over ? lim : r.quo;
		c.val = r.tag.neg ? scr_t'(QUO_W'(-mag)) : scr_t'(mag);
		c.sat = over;
		return c;
	endfunction

	assign cx = clamp_coord(resx);
	assign cy = clamp_coord(resy);

	always_comb begin
		if (resx.tag.wz) begin
			fin_d = '{x: '0, y: '0, wz: 1'b1, sat: 1'b0};
		end else begin
			fin_d = '{x: cx.val, y: cy.val, wz: 1'b0, sat: cx.sat | cy.sat};
		end
	end

	// Final stage
	always_ff @(posedge clk) begin
		if (en) begin
			fin_s <= fin_d;
		end
	end

	// Output register and skid
	assign skid_to_out = skid_vld_q && scr.ready;
	assign load_out    = !skid_vld_q && vld_q[STAGES-1] && (!out_vld_q || scr.ready);
	assign load_skid   = !skid_vld_q && vld_q[STAGES-1] && out_vld_q && !scr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_to_out) begin
				skid_vld_q <= 1'b0;
			end else if (load_skid) begin
				skid_vld_q <= 1'b1;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (!skid_vld_q && scr.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_to_out) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= fin_s;
		end
		if (load_skid) begin
			skid_q <= fin_s;
		end
	end

	assign scr.valid     = out_vld_q;
	assign scr.screen_x  = out_q.x;
	assign scr.screen_y  = out_q.y;
	assign scr.w_zero    = out_q.wz;
	assign scr.saturated = out_q.sat;

endmodule

// ===== src/wts_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the projection block, bound to the top level.
// Depends on wts_pkg and world_to_screen_projection.
module wts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          pos_ready,
	input logic          scr_valid,
	input logic          scr_ready,
	input wts_pkg::scr_t screen_x,
	input wts_pkg::scr_t screen_y,
	input logic          w_zero,
	input logic          saturated
);
	import wts_pkg::*;

	// Zero w gives zero coordinates and no clamp
	a_wzero: assert property (@(posedge clk) disable iff (!arst_n)
		scr_valid && w_zero |-> screen_x == '0 && screen_y == '0 && !saturated)
		else $error("w_zero result with nonzero fields");

	// A clamped result sits on a bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scr_valid && saturated |-> screen_x == OUT_MAX || screen_x == OUT_MIN
			|| screen_y == OUT_MAX || screen_y == OUT_MIN)
		else $error("saturated result off the range bounds");

	// Input backs off only after an output stall
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!pos_ready |-> $past(scr_valid && !scr_ready))
		else $error("input ready dropped without an output stall");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		scr_valid && !scr_ready |=> scr_valid && $stable(screen_x) && $stable(screen_y)
			&& $stable(w_zero) && $stable(saturated))
		else $error("stalled result changed");

endmodule

bind world_to_screen_projection wts_checker u_wts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pos_ready (pos.ready),
	.scr_valid (scr.valid),
	.scr_ready (scr.ready),
	.screen_x  (scr.screen_x),
	.screen_y  (scr.screen_y),
	.w_zero    (scr.w_zero),
	.saturated (scr.saturated)
);

// ===== test/world_to_screen_projection_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the world-to-screen projection block: directed and random positions
// under several matrix settings, checked against an in-bench predictor.
// Depends on wts_pkg, wts_if and world_to_screen_projection.
module world_to_screen_projection_tb;
	import wts_pkg::*;

	typedef struct packed {
		pos_t x;
		pos_t y;
		pos_t z;
	} vertex_t;

	typedef struct packed {
		scr_t sx;
		scr_t sy;
		logic wz;
		logic sat;
	} window_t;

	typedef struct {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pos_if pos ();
	scr_if scr ();
	cfg_if cfg ();

	world_to_screen_projection DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pos(pos),
		.scr(scr),
		.cfg(cfg)
	);

	always #10 clk = ~clk;

	// predictor copy of the matrices
	logic [CFG_DATA_W-1:0] view_m [4];
	logic [CFG_DATA_W-1:0] proj_m [4];

	vertex_t    vertex_q [$];
	window_t    window_q [$];
	reg_write_t regw_q [$];

	int errors = 0;
	int checked = 0;
	int wz_seen = 0;
	int sat_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;

	function automatic longint coef(logic [CFG_DATA_W-1:0] col, int row);
		logic signed [15:0] c;
		c = col[16*row +: 16];
		return longint'(c);
	endfunction

	// num * 2^15 / den truncated toward zero, clamped to 24 bits
	function automatic scr_t window_div(logic signed [127:0] num,
			logic signed [127:0] den, inout logic sat);
		logic signed [127:0] q;
		q = (num * 128'sd32768) / den;
		if (q > 128'sd8388607) begin
			sat = 1'b1;
			return OUT_MAX;
		end else if (q < -128'sd8388608) begin
			sat = 1'b1;
			return OUT_MIN;
		end
		return scr_t'(q[23:0]);
	endfunction

	function automatic window_t project_vertex(vertex_t v);
		longint p [3];
		longint vw [4];
		logic signed [127:0] clip [4];
		logic signed [127:0] acc;
		window_t w;
		logic sat;
		p[0] = longint'(v.x);
		p[1] = longint'(v.y);
		p[2] = longint'(v.z);
		for (int r = 0; r < 4; r++) begin
			vw[r] = coef(view_m[3], r) * 256;
			for (int c = 0; c < 3; c++) vw[r] += coef(view_m[c], r) * p[c];
		end
		for (int r = 0; r < 4; r++) begin
			acc = '0;
			for (int c = 0; c < 4; c++)
				acc += 128'(signed'(coef(proj_m[c], r))) * 128'(signed'(vw[c]));
			clip[r] = acc;
		end
		sat = 1'b0;
		w = '0;
		if (clip[3] == 0) begin
			w.wz = 1'b1;
			return w;
		end
		w.sx = window_div(clip[0] + clip[3], clip[3], sat);
		w.sy = window_div(clip[3] - clip[1], clip[3], sat);
		w.sat = sat;
		return w;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
		$display("MISMATCH %s at %0t: got %h expected %h", what, $realtime, got, exp_v);
		errors++;
	endtask

	// drive positions from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos.valid <= 1'b0;
			pos.pos_x <= '0;
			pos.pos_y <= '0;
			pos.pos_z <= '0;
		end else begin
			vertex_t nv;
			if (!pos.valid || pos.ready) begin
				if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nv = vertex_q.pop_front();
					window_q.push_back(project_vertex(nv));
					pos.valid <= 1'b1;
					pos.pos_x <= nv.x;
					pos.pos_y <= nv.y;
					pos.pos_z <= nv.z;
				end else begin
					pos.valid <= 1'b0;
				end
			end
		end
	end

	// drive register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.index <= '0;
			cfg.data <= '0;
		end else begin
			reg_write_t wr;
			if (!cfg.valid || cfg.ready) begin
				if (regw_q.size() > 0) begin
					wr = regw_q.pop_front();
					cfg.valid <= 1'b1;
					cfg.index <= wr.idx;
					cfg.data <= wr.data;
				end else begin
					cfg.valid <= 1'b0;
				end
			end
		end
	end

	// reset the predictor copy to identity, then apply accepted writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) begin
				view_m[c] <= COEF_ONE << (COEF_W * c);
				proj_m[c] <= COEF_ONE << (COEF_W * c);
			end
		end else if (cfg.valid && cfg.ready) begin
			if (cfg_idx_t'(cfg.index) < CFG_PROJ_COL0) view_m[cfg.index[1:0]] <= cfg.data;
			else proj_m[cfg.index[1:0]] <= cfg.data;
		end
	end

	// stall the output and check each accepted result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr.ready <= 1'b0;
		end else begin
			window_t e;
			if (scr.valid && scr.ready) begin
				if (window_q.size() == 0) begin
					report_mismatch("unexpected result", 64'({scr.screen_x, scr.screen_y}),
						64'(0));
				end else begin
					e = window_q.pop_front();
					checked++;
					if (e.wz) wz_seen++;
					if (e.sat) sat_seen++;
					if (scr.screen_x !== e.sx)
						report_mismatch("screen_x", 64'(scr.screen_x), 64'(e.sx));
					if (scr.screen_y !== e.sy)
						report_mismatch("screen_y", 64'(scr.screen_y), 64'(e.sy));
					if (scr.w_zero !== e.wz)
						report_mismatch("w_zero", 64'(scr.w_zero), 64'(e.wz));
					if (scr.saturated !== e.sat)
						report_mismatch("saturated", 64'(scr.saturated), 64'(e.sat));
				end
			end
			scr.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((pos.valid && pos.ready) || (scr.valid && scr.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding", window_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] rand_col();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(5))
			0: return 16'h1000;
			1: return 16'hF000;
			2: return 16'h0000;
			3: return 16'h7FFF;
			4: return 16'h8000;
			default: return 16'($urandom_range(16'h2000)) - 16'h1000;
		endcase
	endfunction

	function automatic vertex_t rand_vertex();
		vertex_t v;
		if ($urandom_range(3) == 0) begin
			v = {16'($urandom()), 16'($urandom()), 16'($urandom())};
		end else begin
			v.x = pos_t'($signed(16'($urandom_range(2048))) - 16'sd1024);
			v.y = pos_t'($signed(16'($urandom_range(2048))) - 16'sd1024);
			v.z = pos_t'($signed(16'($urandom_range(2048))) - 16'sd1024);
		end
		return v;
	endfunction

	// wait for every result, then let the pipeline settle
	task automatic drain();
		while (vertex_q.size() > 0 || window_q.size() > 0 || pos.valid) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_matrices(logic [63:0] v [4], logic [63:0] p [4]);
		reg_write_t wr;
		for (int i = 0; i < 4; i++) begin
			wr.idx = CFG_IDX_W'(CFG_VIEW_COL0 + i);
			wr.data = v[i];
			regw_q.push_back(wr);
			wr.idx = CFG_IDX_W'(CFG_PROJ_COL0 + i);
			wr.data = p[i];
			regw_q.push_back(wr);
		end
		while (regw_q.size() > 0 || cfg.valid) @(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		logic [63:0] vm [4];
		logic [63:0] pm [4];
		logic [15:0] pv [4];
		int idle_tab [4][2];
		mat_t id_m;
		idle_tab = '{'{0, 0}, '{60, 0}, '{0, 60}, '{19, 19}};
		id_m = ident_mat();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrices: extremes of every field, w stays one
		vertex_q.push_back({16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		vertex_q.push_back({16'sh8000, 16'sh8000, 16'sh8000});
		vertex_q.push_back({16'sh0000, 16'sh0000, 16'sh0000});
		vertex_q.push_back({16'sh0100, 16'shFF00, 16'sh0080});
		vertex_q.push_back({16'shFFFF, 16'sh0001, 16'sh5555});
		vertex_q.push_back({16'shAAAA, 16'sh5555, 16'shAAAA});
		drain();

		// perspective-like projection: w from -z, zero at z = 0, negative beyond
		for (int i = 0; i < 4; i++) vm[i] = id_m[i];
		pm[0] = 64'h1000;
		pm[1] = 64'h1000 << 16;
		pm[2] = {16'hF000, 16'h0000, 16'h0000, 16'h0000};
		pm[3] = 64'h0;
		write_matrices(vm, pm);
		vertex_q.push_back({16'sh0100, 16'sh0100, 16'sh0000});
		vertex_q.push_back({16'sh0100, 16'shFF00, 16'shFF00});
		vertex_q.push_back({16'sh0100, 16'sh0100, 16'sh0100});
		vertex_q.push_back({16'sh7FFF, 16'sh8000, 16'shFFFF});
		vertex_q.push_back({16'sh8000, 16'sh7FFF, 16'sh0001});
		vertex_q.push_back({16'sh7FFF, 16'sh7FFF, 16'sh8000});
		drain();

		// extreme coefficients everywhere
		for (int i = 0; i < 4; i++) begin
			vm[i] = {4{16'h7FFF}};
			pm[i] = {4{16'h8000}};
		end
		write_matrices(vm, pm);
		vertex_q.push_back({16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
		vertex_q.push_back({16'sh8000, 16'sh8000, 16'sh8000});
		vertex_q.push_back({16'sh8000, 16'sh7FFF, 16'sh0000});
		drain();

		// random phases: each setting runs under one idling mix, the four mixes in turn
		for (int ph = 0; ph < 8; ph++) begin
			for (int i = 0; i < 4; i++) begin
				for (int r = 0; r < 4; r++) pv[r] = rand_coef();
				vm[i] = (ph == 7) ? rand_col() : {pv[3], pv[2], pv[1], pv[0]};
				for (int r = 0; r < 4; r++) pv[r] = rand_coef();
				pm[i] = (ph == 7) ? rand_col() : {pv[3], pv[2], pv[1], pv[0]};
			end
			if (ph == 0) begin
				for (int i = 0; i < 4; i++) begin
					vm[i] = id_m[i];
					pm[i] = id_m[i];
				end
			end
			write_matrices(vm, pm);
			send_idle_pct = idle_tab[ph % 4][0];
			recv_stall_pct = idle_tab[ph % 4][1];
			for (int n = 0; n < 205; n++) begin
				vertex_q.push_back(($urandom_range(15) == 0) ?
					vertex_t'({16'($urandom()), 16'($urandom()), 16'h0000}) :
					rand_vertex());
			end
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;

		$display("Checked %0d projected vertices over 11 matrix settings", checked);
		$display("%0d had zero clip w, %0d saturated", wz_seen, sat_seen);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
